@@ design/movd_pkg.sv @@
// Package for the 16-bit MOV decoder: word types, opcode patterns and form codes.
// No dependencies; used by movd_decode and mov_instruction_decoder_16bit_unit.
package movd_pkg;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [7:0] byte4;
      logic [7:0] byte5;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  form;
      logic        wide;
      logic        reg_is_dest;
      logic [2:0]  reg_index;
      logic [1:0]  addr_mode;
      logic [2:0]  rm_index;
      logic        direct_address;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [2:0]  length;
   } rsp_word_type;

   // form codes
   localparam logic [2:0] FORM_RM_REG   = 3'd0;
   localparam logic [2:0] FORM_IMM_RM   = 3'd1;
   localparam logic [2:0] FORM_IMM_REG  = 3'd2;
   localparam logic [2:0] FORM_MEM_ACC  = 3'd3;
   localparam logic [2:0] FORM_ACC_MEM  = 3'd4;
   localparam logic [2:0] FORM_RM_SREG  = 3'd5;
   localparam logic [2:0] FORM_SREG_RM  = 3'd6;
   localparam logic [2:0] FORM_UNSUP    = 3'd7;

   // opcode patterns and masks
   localparam logic [7:0] OP_RM_REG   = 8'h88;
   localparam logic [7:0] OP_IMM_RM   = 8'hC6;
   localparam logic [7:0] OP_IMM_REG  = 8'hB0;
   localparam logic [7:0] OP_MEM_ACC  = 8'hA0;
   localparam logic [7:0] OP_ACC_MEM  = 8'hA2;
   localparam logic [7:0] OP_RM_SREG  = 8'h8E;
   localparam logic [7:0] OP_SREG_RM  = 8'h8C;
   localparam logic [7:0] MASK_DW     = 8'hFC;
   localparam logic [7:0] MASK_W      = 8'hFE;
   localparam logic [7:0] MASK_HIGH   = 8'hF0;

   // MOD field values and the R/M code that means direct address
   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP16  = 2'd2;
   localparam logic [2:0] RM_DIRECT   = 3'd6;

endpackage

@@ design/movd_decode.sv @@
// Combinational decode of one six-byte MOV window into a result word.
// Depends on movd_pkg for the word types, opcode patterns and form codes.
module movd_decode
   import movd_pkg::*;
(
   input  req_word_type in_word,
   output rsp_word_type out_word
);

   logic [7:0] b0, b1, b2, b3, b4, b5;
   logic [1:0] mod_field;
   logic [2:0] reg_field;
   logic [2:0] rm_field;
   logic [2:0] base_len;
   logic [7:0] imm_lo;
   logic [7:0] imm_hi;

   assign b0 = in_word.byte0;
   assign b1 = in_word.byte1;
   assign b2 = in_word.byte2;
   assign b3 = in_word.byte3;
   assign b4 = in_word.byte4;
   assign b5 = in_word.byte5;

   assign mod_field = b1[7:6];
   assign reg_field = b1[5:3];
   assign rm_field  = b1[2:0];

   // length of the opcode, mod-reg-rm and displacement bytes
   always_comb begin
      if (mod_field == MOD_NO_DISP && rm_field == RM_DIRECT) begin
         base_len = 3'd4;
      end else if (mod_field == MOD_DISP8) begin
         base_len = 3'd3;
      end else if (mod_field == MOD_DISP16) begin
         base_len = 3'd4;
      end else begin
         base_len = 3'd2;
      end
   end

   // immediate of the imm-to-r/m form follows the displacement
   always_comb begin
      unique case (base_len)
         3'd3: begin
            imm_lo = b3;
            imm_hi = b4;
         end
         3'd4: begin
            imm_lo = b4;
            imm_hi = b5;
         end
         default: begin
            imm_lo = b2;
            imm_hi = b3;
         end
      endcase
   end

   always_comb begin
      out_word = '0;
      out_word.form   = FORM_UNSUP;
      out_word.length = 3'd2;
      priority if ((b0 & MASK_DW) == OP_RM_REG || (b0 & MASK_W) == OP_IMM_RM) begin
         out_word.form        = ((b0 & MASK_DW) == OP_RM_REG) ? FORM_RM_REG : FORM_IMM_RM;
         out_word.wide        = b0[0];
         out_word.reg_is_dest = ((b0 & MASK_DW) == OP_RM_REG) ? b0[1] : 1'b0;
         out_word.addr_mode   = mod_field;
         out_word.reg_index   = reg_field;
         out_word.rm_index    = rm_field;
         if (mod_field == MOD_NO_DISP && rm_field == RM_DIRECT) begin
            out_word.direct_address = 1'b1;
            out_word.displacement   = {b3, b2};
         end else if (mod_field == MOD_DISP8) begin
            out_word.displacement   = {{8{b2[7]}}, b2};
         end else if (mod_field == MOD_DISP16) begin
            out_word.displacement   = {b3, b2};
         end
         if ((b0 & MASK_DW) == OP_RM_REG) begin
            out_word.length = base_len;
         end else begin
            out_word.immediate = b0[0] ? {imm_hi, imm_lo} : {8'h00, imm_lo};
            out_word.length    = base_len + 3'd1 + {2'b00, b0[0]};
         end
      end else if ((b0 & MASK_HIGH) == OP_IMM_REG) begin
         out_word.form        = FORM_IMM_REG;
         out_word.wide        = b0[3];
         out_word.reg_index   = b0[2:0];
         out_word.reg_is_dest = 1'b1;
         out_word.immediate   = b0[3] ? {b2, b1} : {8'h00, b1};
         out_word.length      = 3'd2 + {2'b00, b0[3]};
      end else if ((b0 & MASK_W) == OP_MEM_ACC || (b0 & MASK_W) == OP_ACC_MEM) begin
         out_word.form           = ((b0 & MASK_W) == OP_MEM_ACC) ? FORM_MEM_ACC : FORM_ACC_MEM;
         out_word.wide           = b0[0];
         out_word.reg_is_dest    = ((b0 & MASK_W) == OP_MEM_ACC);
         out_word.rm_index       = RM_DIRECT;
         out_word.direct_address = 1'b1;
         out_word.displacement   = {b2, b1};
         out_word.length         = 3'd3;
      end else if (b0 == OP_RM_SREG) begin
         out_word.form = FORM_RM_SREG;
      end else if (b0 == OP_SREG_RM) begin
         out_word.form = FORM_SREG_RM;
      end else begin
         out_word.form = FORM_UNSUP;
      end
   end

endmodule

@@ design/mov_instruction_decoder_16bit_unit.sv @@
// 16-bit MOV decoder top level: input register, decode, result register.
// Throughput: one word per cycle; the only limit is the response stall,
// which stops the result register, and the input register when it is full.
// Reset (synchronous, active high) clears both valid flags; no other state.
// Depends on movd_pkg and movd_decode.
module mov_instruction_decoder_16bit_unit
   import movd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_word_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type dec_word;
   logic         rsp_advance;
   logic         s1_advance;

   // result register can load when empty or being taken this cycle
   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = !s1_valid_ff || rsp_advance;
   assign req_stall   = !s1_advance;

   assign s1_valid_in  = s1_advance ? req_valid : s1_valid_ff;
   assign rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;

   movd_decode u_decode (
      .in_word  (s1_word_ff),
      .out_word (dec_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_word_ff <= req_word;
      end
      if (rsp_advance) begin
         rsp_word_ff <= dec_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // hold the input register while the result register is stalled
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> (s1_valid_ff && $stable(s1_word_ff)))
      else $error("input register changed under a stalled result");

   // a stalled request must not be dropped: stall only when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipe");

   a_short_forms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.form == FORM_RM_SREG || rsp_word_ff.form == FORM_SREG_RM
         || rsp_word_ff.form == FORM_UNSUP)) |-> (rsp_word_ff.length == 3'd2
         && rsp_word_ff.displacement == 16'h0000 && rsp_word_ff.immediate == 16'h0000))
      else $error("segment or unsupported form with nonzero fields");

   a_direct_mod: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.direct_address) |->
         (rsp_word_ff.addr_mode == MOD_NO_DISP && rsp_word_ff.rm_index == RM_DIRECT))
      else $error("direct address flagged with wrong MOD or R/M");

   a_imm_reg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.form == FORM_IMM_REG) |->
         (rsp_word_ff.length == 3'd2 + {2'b00, rsp_word_ff.wide}
          && rsp_word_ff.displacement == 16'h0000))
      else $error("imm-to-reg length or displacement wrong");

endmodule
